>>> rtl/core/bcpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier point evaluator package
// Widths, register indexes and shared types for the de Casteljau pipeline.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int COORD_W   = 32;                   // Q16.16 coordinate
    localparam int FRAC_W    = 16;
    localparam int T_W       = 17;                   // Q1.16 parameter
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + T_W + 1;
    localparam int CNT_W     = 3;
    localparam int POINT_W   = 2 * COORD_W;
    localparam int REG_POINTS = 7;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_POINTS = 7;

    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_0     = CFG_IDX_W'(1);

    typedef logic signed [COORD_W-1:0] t_coord;

    // matches the register layout: x in the upper half, y in the lower half
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // side information that travels with each item through the pipeline
    typedef struct packed {
        logic [T_W-1:0]   t_param;
        logic [CNT_W-1:0] count;
    } t_tag;

endpackage
`default_nettype wire

>>> rtl/core/bcpe_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier point evaluator input channel
// Valid/ready channel carrying one curve parameter per item.
// ----------------------------------------------------------------------------
interface bcpe_in_if;
    import bcpe_pkg::*;

    logic           valid;
    logic           ready;
    logic [T_W-1:0] t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);

endinterface
`default_nettype wire

>>> rtl/core/bcpe_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier point evaluator output channel
// Valid/ready channel carrying one curve point per item.
// ----------------------------------------------------------------------------
interface bcpe_out_if;
    import bcpe_pkg::*;

    logic   valid;
    logic   ready;
    t_coord x_coord;
    t_coord y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);

endinterface
`default_nettype wire

>>> rtl/core/bcpe_lerp_level.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier point evaluator: one de Casteljau level
// Reduces NUM_IN points to NUM_IN-1 by rounded linear interpolation in three
// register stages: difference, product, rounded add. A level that the point
// count does not use passes the leading points through unchanged.
// ----------------------------------------------------------------------------
module bcpe_lerp_level #(
    parameter int NUM_IN     = 7,
    parameter int LVL        = 0,
    parameter int MAX_POINTS = bcpe_pkg::DEF_MAX_POINTS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire bcpe_pkg::t_tag                      i_tag,
    input  wire bcpe_pkg::t_point [NUM_IN-1:0]       i_pts,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output bcpe_pkg::t_tag                           o_tag,
    output bcpe_pkg::t_point [NUM_IN-2:0]            o_pts
);
    import bcpe_pkg::*;

    localparam int NUM_OUT = NUM_IN - 1;

    // stage 1: difference
    logic                     r_v1;
    t_tag                     r_tag1;
    t_point                   r_a1  [NUM_OUT];
    logic signed [DIFF_W-1:0] r_dx1 [NUM_OUT];
    logic signed [DIFF_W-1:0] r_dy1 [NUM_OUT];
    // stage 2: product
    logic                     r_v2;
    t_tag                     r_tag2;
    t_point                   r_a2  [NUM_OUT];
    logic signed [PROD_W-1:0] r_px2 [NUM_OUT];
    logic signed [PROD_W-1:0] r_py2 [NUM_OUT];
    // stage 3: rounded sum
    logic                     r_v3;
    t_tag                     r_tag3;
    t_point [NUM_OUT-1:0]     r_res3;

    logic                     w_en1, w_en2, w_en3;
    logic                     w_active;
    logic signed [T_W:0]      w_t_s;

    // collapse bubbles: a stage loads when empty or when it drains this cycle
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // the first MAX_POINTS-count levels only drop the last point
    assign w_active = (int'(i_tag.count) + LVL) >= MAX_POINTS;
    assign w_t_s    = $signed({1'b0, r_tag1.t_param});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_tag1 <= i_tag;
            for (int k = 0; k < NUM_OUT; k++) begin
                r_a1[k] <= i_pts[k];
                // zero difference turns the lerp into a pass-through
                if (w_active) begin
                    r_dx1[k] <= DIFF_W'(i_pts[k+1].x) - DIFF_W'(i_pts[k].x);
                    r_dy1[k] <= DIFF_W'(i_pts[k+1].y) - DIFF_W'(i_pts[k].y);
                end else begin
                    r_dx1[k] <= '0;
                    r_dy1[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_tag2 <= r_tag1;
            for (int k = 0; k < NUM_OUT; k++) begin
                r_a2[k]  <= r_a1[k];
                r_px2[k] <= PROD_W'(r_dx1[k]) * PROD_W'(w_t_s);
                r_py2[k] <= PROD_W'(r_dy1[k]) * PROD_W'(w_t_s);
            end
        end
    end

    // the lerp stays between its operands, so the 32-bit sum cannot wrap
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_tag3 <= r_tag2;
            for (int k = 0; k < NUM_OUT; k++) begin
                r_res3[k].x <= r_a2[k].x
                             + COORD_W'((r_px2[k] + ROUND_HALF) >>> FRAC_W);
                r_res3[k].y <= r_a2[k].y
                             + COORD_W'((r_py2[k] + ROUND_HALF) >>> FRAC_W);
            end
        end
    end

    assign o_valid = r_v3;
    assign o_tag   = r_tag3;
    assign o_pts   = r_res3;

endmodule
`default_nettype wire

>>> rtl/core/bezier_curve_point_eval_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Evaluates a 2-D Bezier curve of up to MAX_POINTS control points at one
// Q1.16 parameter per item by de Casteljau reduction in fixed point.
// ----------------------------------------------------------------------------
// Pipeline: entry register, three stages per level, output register.
// Throughput: one item per cycle while the output is not stalled; each level owns its multipliers.
// Reset clears all valid bits, the point count and the control points.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval_unit #(
    parameter int MAX_POINTS = bcpe_pkg::DEF_MAX_POINTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bcpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcpe_pkg::POINT_W-1:0]   i_cfg_data,
    bcpe_in_if.sink                             i_in,
    bcpe_out_if.source                          o_out
);
    import bcpe_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // configuration
    logic [CNT_W-1:0] r_count;
    t_point           r_points [REG_POINTS];

    // entry stage
    logic             r_in_valid;
    t_tag             r_in_tag;
    t_point [MAX_POINTS-1:0] r_in_pts;
    logic             w_in_en;
    t_tag             w_in_tag;

    // level links: index j feeds level j, the last one feeds the output stage
    logic                    w_vld [MAX_POINTS];
    logic                    w_rdy [MAX_POINTS];
    t_tag                    w_tag [MAX_POINTS];
    t_point [MAX_POINTS-1:0] w_pts [MAX_POINTS];

    // output stage
    logic   r_out_valid;
    t_point r_out_pt;
    logic   w_out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < REG_POINTS; k++) begin
                r_points[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_POINT_COUNT) begin
                r_count <= i_cfg_data[CNT_W-1:0];
            end else begin
                r_points[i_cfg_idx - CFG_POINT_0] <= t_point'(i_cfg_data);
            end
        end
    end

    // clamp the parameter to one and the count to the pipeline depth
    always_comb begin
        w_in_tag.t_param = (i_in.t_param > T_ONE) ? T_ONE : i_in.t_param;
        w_in_tag.count   = (r_count > MAX_CNT) ? MAX_CNT : r_count;
    end

    assign w_in_en    = !r_in_valid || w_rdy[0];
    assign i_in.ready = w_in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_en) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en) begin
            r_in_tag <= w_in_tag;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_in_pts[k] <= r_points[k];
            end
        end
    end

    assign w_vld[0] = r_in_valid;
    assign w_tag[0] = r_in_tag;
    assign w_pts[0] = r_in_pts;

    for (genvar j = 0; j < MAX_POINTS - 1; j++) begin : g_level
        bcpe_lerp_level #(
            .NUM_IN     (MAX_POINTS - j),
            .LVL        (j),
            .MAX_POINTS (MAX_POINTS)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[j]),
            .o_ready (w_rdy[j]),
            .i_tag   (w_tag[j]),
            .i_pts   (w_pts[j][MAX_POINTS-1-j:0]),
            .o_valid (w_vld[j+1]),
            .i_ready (w_rdy[j+1]),
            .o_tag   (w_tag[j+1]),
            .o_pts   (w_pts[j+1][MAX_POINTS-2-j:0])
        );
        // points dropped by the reduction so far
        assign w_pts[j+1][MAX_POINTS-1:MAX_POINTS-1-j] = '0;
    end

    assign w_out_en              = !r_out_valid || o_out.ready;
    assign w_rdy[MAX_POINTS-1]   = w_out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= w_vld[MAX_POINTS-1];
        end
    end

    // no points in use: the origin
    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            if (w_tag[MAX_POINTS-1].count == '0) begin
                r_out_pt <= '0;
            end else begin
                r_out_pt <= w_pts[MAX_POINTS-1][0];
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.x_coord = r_out_pt.x;
    assign o_out.y_coord = r_out_pt.y;

    a_in_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_in_tag.t_param <= T_ONE))
        else $error("entry stage holds a parameter above one");

    a_in_cnt_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_in_tag.count <= MAX_CNT))
        else $error("entry stage holds a count above the pipeline depth");

    a_entry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_rdy[0]) |=> (r_in_valid && $stable(r_in_tag)))
        else $error("stalled entry item was lost or changed");

    a_out_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_en && w_vld[MAX_POINTS-1] && (w_tag[MAX_POINTS-1].count == '0))
        |=> (o_out.valid && (o_out.x_coord == '0) && (o_out.y_coord == '0)))
        else $error("zero point count did not give the origin");

endmodule
`default_nettype wire
